[sv/utq_pkg.sv]
// shared types and constants for the uart transmit queue
package utq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int QAW         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW          = $clog2(QUEUE_DEPTH + 1);
   localparam int FILL_W      = 7;
   localparam int BYTE_W      = 8;

   localparam int OPQ_DEPTH   = 4;
   localparam int OPQ_AW      = $clog2(OPQ_DEPTH);
   localparam int OPQ_CW      = $clog2(OPQ_DEPTH + 1);

   localparam logic OP_PUT    = 1'b0;
   localparam logic OP_EVENT  = 1'b1;

   localparam logic [BYTE_W-1:0] LINE_FEED       = 8'h0A;
   localparam logic [BYTE_W-1:0] CARRIAGE_RETURN = 8'h0D;

   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] data;
      logic              tx_empty;
      logic              chain;
      logic              last;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } push_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } head_type;

endpackage

[sv/utq_front.sv]
// front end: takes items, expands a line feed into carriage return and line feed
module utq_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic [7:0]         req_tx_char,
   input  logic               req_transmitter_empty,
   input  logic               opq_full,
   output utq_pkg::push_type  push
);

   logic            pend_valid_ff, pend_valid_in;
   utq_pkg::op_type pend_op_ff, pend_op_in;
   logic            accept;
   logic            is_lf;

   assign req_stall = pend_valid_ff || opq_full;
   assign accept    = req_valid && !req_stall;
   assign is_lf     = (req_operation == utq_pkg::OP_PUT) && (req_tx_char == utq_pkg::LINE_FEED);

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_op_in    = pend_op_ff;
      push.valid    = 1'b0;
      push.op       = pend_op_ff;
      if (pend_valid_ff) begin
         if (!opq_full) begin
            push.valid    = 1'b1;
            pend_valid_in = 1'b0;
         end
      end else if (accept) begin
         push.valid       = 1'b1;
         push.op.kind     = req_operation;
         push.op.data     = req_tx_char;
         push.op.tx_empty = req_transmitter_empty;
         push.op.chain    = 1'b0;
         push.op.last     = 1'b1;
         if (is_lf) begin
            // carriage return goes first, line feed waits in the pending register
            push.op.data        = utq_pkg::CARRIAGE_RETURN;
            push.op.last        = 1'b0;
            pend_valid_in       = 1'b1;
            pend_op_in.kind     = utq_pkg::OP_PUT;
            pend_op_in.data     = utq_pkg::LINE_FEED;
            pend_op_in.tx_empty = req_transmitter_empty;
            pend_op_in.chain    = 1'b1;
            pend_op_in.last     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
      pend_op_ff <= pend_op_in;
   end

endmodule

[sv/utq_opq.sv]
// short queue of operations between front and back
module utq_opq (
   input  logic               clock,
   input  logic               reset,
   input  utq_pkg::push_type  push,
   output logic               full,
   output utq_pkg::head_type  head,
   input  logic               pop
);

   utq_pkg::op_type                  slot_ff [utq_pkg::OPQ_DEPTH];
   logic [utq_pkg::OPQ_AW-1:0]       wptr_ff, wptr_in;
   logic [utq_pkg::OPQ_AW-1:0]       rptr_ff, rptr_in;
   logic [utq_pkg::OPQ_CW-1:0]       count_ff, count_in;
   logic                             do_push, do_pop;

   assign full       = (count_ff == utq_pkg::OPQ_CW'(utq_pkg::OPQ_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.op    = slot_ff[rptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wptr_in  = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         slot_ff[wptr_ff] <= push.op;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= utq_pkg::OPQ_CW'(utq_pkg::OPQ_DEPTH))
      else $error("op queue count overflow");
   a_push_kept: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("op queue lost a push");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> !do_pop)
      else $error("op queue popped while empty");

endmodule

[sv/utq_back.sv]
// back end: byte queue, data register writes and the result register
module utq_back (
   input  logic               clock,
   input  logic               reset,
   input  utq_pkg::head_type  head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_dr_write,
   output logic [7:0]         rsp_dr_byte,
   output logic               rsp_irq_enable,
   output logic               rsp_rejected_full,
   output logic [6:0]         rsp_fill_level,
   output logic               rsp_last
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_POP  = 1'b1;

   logic [utq_pkg::BYTE_W-1:0] mem [utq_pkg::QUEUE_DEPTH];
   logic [utq_pkg::BYTE_W-1:0] rd_data_ff;

   logic                       state_ff, state_in;
   logic [utq_pkg::QAW-1:0]    wptr_ff, wptr_in;
   logic [utq_pkg::QAW-1:0]    rptr_ff, rptr_in;
   logic [utq_pkg::CW-1:0]     count_ff, count_in;
   logic                       irq_ff, irq_in;
   logic                       prev_direct_ff, prev_direct_in;

   logic                       out_valid_ff, out_valid_in;
   logic                       out_write_ff, out_write_in;
   logic [utq_pkg::BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic                       out_rej_ff, out_rej_in;
   logic                       out_last_ff, out_last_in;

   logic                       slot_free;
   logic                       tx_free;
   logic                       wr_en, rd_en;

   assign slot_free = !out_valid_ff || !rsp_stall;
   assign tx_free   = head.op.tx_empty && !(head.op.chain && prev_direct_ff);

   always_comb begin
      state_in       = state_ff;
      wptr_in        = wptr_ff;
      rptr_in        = rptr_ff;
      count_in       = count_ff;
      irq_in         = irq_ff;
      prev_direct_in = prev_direct_ff;
      out_valid_in   = out_valid_ff && rsp_stall;
      out_write_in   = out_write_ff;
      out_byte_in    = out_byte_ff;
      out_rej_in     = out_rej_ff;
      out_last_in    = out_last_ff;
      pop            = 1'b0;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (head.valid && slot_free) begin
               pop          = 1'b1;
               out_write_in = 1'b0;
               out_byte_in  = '0;
               out_rej_in   = 1'b0;
               out_last_in  = head.op.last;
               if (head.op.kind == utq_pkg::OP_PUT) begin
                  out_valid_in   = 1'b1;
                  prev_direct_in = 1'b0;
                  if (count_ff == '0 && tx_free) begin
                     out_write_in   = 1'b1;
                     out_byte_in    = head.op.data;
                     prev_direct_in = 1'b1;
                  end else if (count_ff == utq_pkg::CW'(utq_pkg::QUEUE_DEPTH)) begin
                     out_rej_in = 1'b1;
                  end else begin
                     wr_en    = 1'b1;
                     wptr_in  = (wptr_ff == utq_pkg::QAW'(utq_pkg::QUEUE_DEPTH - 1)) ?
                                '0 : wptr_ff + 1'b1;
                     count_in = count_ff + 1'b1;
                     irq_in   = 1'b1;
                  end
               end else if (head.op.tx_empty && count_ff != '0) begin
                  rd_en    = 1'b1;
                  state_in = S_POP;
               end else begin
                  out_valid_in = 1'b1;
                  if (head.op.tx_empty) begin
                     irq_in = 1'b0;
                  end
               end
            end
         end
         S_POP: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_write_in = 1'b1;
               out_byte_in  = rd_data_ff;
               out_rej_in   = 1'b0;
               out_last_in  = 1'b1;
               rptr_in      = (rptr_ff == utq_pkg::QAW'(utq_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rptr_ff + 1'b1;
               count_in     = count_ff - 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wptr_ff] <= head.op.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         wptr_ff        <= '0;
         rptr_ff        <= '0;
         count_ff       <= '0;
         irq_ff         <= 1'b0;
         prev_direct_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         wptr_ff        <= wptr_in;
         rptr_ff        <= rptr_in;
         count_ff       <= count_in;
         irq_ff         <= irq_in;
         prev_direct_ff <= prev_direct_in;
         out_valid_ff   <= out_valid_in;
      end
      out_write_ff <= out_write_in;
      out_byte_ff  <= out_byte_in;
      out_rej_ff   <= out_rej_in;
      out_last_ff  <= out_last_in;
   end

   // irq and fill level follow the state after the latest result
   assign rsp_valid         = out_valid_ff;
   assign rsp_dr_write      = out_write_ff;
   assign rsp_dr_byte       = out_byte_ff;
   assign rsp_irq_enable    = irq_ff;
   assign rsp_rejected_full = out_rej_ff;
   assign rsp_fill_level    = utq_pkg::FILL_W'(count_ff);
   assign rsp_last          = out_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= utq_pkg::CW'(utq_pkg::QUEUE_DEPTH))
      else $error("byte queue count overflow");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_POP |-> count_ff != '0)
      else $error("pop from empty byte queue");
   a_reject_no_write: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_rej_ff |-> !out_write_ff && count_ff == utq_pkg::CW'(utq_pkg::QUEUE_DEPTH))
      else $error("reject while queue not full");
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_write_ff |-> out_byte_ff == '0)
      else $error("byte shown without a write");

endmodule

[sv/uart_tx_queue_with_crlf.sv]
// top level of the uart transmit queue with line feed expansion
//
//   channel  direction  handshake               fields
//   req      in         req_valid / req_stall   operation, tx_char, transmitter_empty
//   rsp      out        rsp_valid / rsp_stall   dr_write, dr_byte, irq_enable,
//                                               rejected_full, fill_level, last
//
// puts and idle events give their result from S_IDLE, an event that pops a byte goes
// through S_POP (registered read of the byte store); a line feed item gives two results
// a line feed holds the input while its second op waits in the pending register
// synchronous reset clears pointers, counts and the enable; the byte store is not cleared
// stalls on rsp back up through the op queue and the front end to req
module uart_tx_queue_with_crlf (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_operation,
   input  logic [7:0] req_tx_char,
   input  logic       req_transmitter_empty,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_dr_write,
   output logic [7:0] rsp_dr_byte,
   output logic       rsp_irq_enable,
   output logic       rsp_rejected_full,
   output logic [6:0] rsp_fill_level,
   output logic       rsp_last
);

   utq_pkg::push_type push;
   utq_pkg::head_type head;
   logic              opq_full;
   logic              pop;

   utq_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_operation         (req_operation),
      .req_tx_char           (req_tx_char),
      .req_transmitter_empty (req_transmitter_empty),
      .opq_full              (opq_full),
      .push                  (push)
   );

   utq_opq u_opq (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (opq_full),
      .head  (head),
      .pop   (pop)
   );

   utq_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_dr_write      (rsp_dr_write),
      .rsp_dr_byte       (rsp_dr_byte),
      .rsp_irq_enable    (rsp_irq_enable),
      .rsp_rejected_full (rsp_rejected_full),
      .rsp_fill_level    (rsp_fill_level),
      .rsp_last          (rsp_last)
   );

endmodule

[dv/tb_uart_tx_queue_with_crlf.sv]
// testbench for the uart transmit queue with line feed expansion
`timescale 1ns / 100ps

module tb_uart_tx_queue_with_crlf;

   localparam int RANDOM_ITEMS = 1450;
   localparam int HOLD_CYCLES  = 400;
   localparam int STUCK_LIMIT  = 3000;
   localparam int SETTLE       = 20;

   localparam logic       PUT = utq_pkg::OP_PUT;
   localparam logic       EVT = utq_pkg::OP_EVENT;
   localparam logic [7:0] LF  = utq_pkg::LINE_FEED;
   localparam logic [7:0] CR  = utq_pkg::CARRIAGE_RETURN;

   typedef struct packed {
      logic                       dr_write;
      logic [utq_pkg::BYTE_W-1:0] dr_byte;
      logic                       irq_enable;
      logic                       rejected_full;
      logic [utq_pkg::FILL_W-1:0] fill_level;
      logic                       last;
   } tx_result_type;

   typedef struct packed {
      logic                       op;
      logic [utq_pkg::BYTE_W-1:0] ch;
      logic                       te;
      logic [7:0]                 reps;
      logic                       typed;
      tx_result_type              res;
   } stim_row_type;

   localparam tx_result_type NO_RES = '0;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_operation;
   logic [7:0] req_tx_char;
   logic       req_transmitter_empty;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_dr_write;
   logic [7:0] rsp_dr_byte;
   logic       rsp_irq_enable;
   logic       rsp_rejected_full;
   logic [6:0] rsp_fill_level;
   logic       rsp_last;

   uart_tx_queue_with_crlf dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_operation         (req_operation),
      .req_tx_char           (req_tx_char),
      .req_transmitter_empty (req_transmitter_empty),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_dr_write          (rsp_dr_write),
      .rsp_dr_byte           (rsp_dr_byte),
      .rsp_irq_enable        (rsp_irq_enable),
      .rsp_rejected_full     (rsp_rejected_full),
      .rsp_fill_level        (rsp_fill_level),
      .rsp_last              (rsp_last)
   );

   stim_row_type directed_rows [0:22] = '{
      '{PUT, 8'h00, 1'b1, 8'd1,  1'b1, '{1'b1, 8'h00, 1'b0, 1'b0, 7'd0,  1'b1}},
      '{PUT, 8'hFF, 1'b0, 8'd1,  1'b1, '{1'b0, 8'h00, 1'b1, 1'b0, 7'd1,  1'b1}},
      '{EVT, 8'h5A, 1'b0, 8'd1,  1'b1, '{1'b0, 8'h00, 1'b1, 1'b0, 7'd1,  1'b1}},
      '{EVT, 8'hA5, 1'b1, 8'd1,  1'b1, '{1'b1, 8'hFF, 1'b1, 1'b0, 7'd0,  1'b1}},
      '{EVT, 8'h00, 1'b1, 8'd1,  1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 7'd0,  1'b1}},
      '{PUT, LF,    1'b1, 8'd1,  1'b0, NO_RES},
      '{PUT, LF,    1'b0, 8'd1,  1'b0, NO_RES},
      '{EVT, 8'h3C, 1'b1, 8'd3,  1'b0, NO_RES},
      '{EVT, 8'hC3, 1'b1, 8'd1,  1'b0, NO_RES},
      '{PUT, 8'h55, 1'b0, 8'd63, 1'b0, NO_RES},
      '{PUT, LF,    1'b0, 8'd1,  1'b0, NO_RES},
      '{PUT, 8'hAA, 1'b0, 8'd1,  1'b1, '{1'b0, 8'h00, 1'b1, 1'b1, 7'd64, 1'b1}},
      '{PUT, 8'h80, 1'b1, 8'd1,  1'b1, '{1'b0, 8'h00, 1'b1, 1'b1, 7'd64, 1'b1}},
      '{PUT, LF,    1'b1, 8'd1,  1'b0, NO_RES},
      '{EVT, 8'h0F, 1'b0, 8'd1,  1'b1, '{1'b0, 8'h00, 1'b1, 1'b0, 7'd64, 1'b1}},
      '{EVT, 8'hF0, 1'b1, 8'd64, 1'b0, NO_RES},
      '{EVT, 8'h00, 1'b1, 8'd1,  1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 7'd0,  1'b1}},
      '{PUT, 8'h01, 1'b1, 8'd1,  1'b1, '{1'b1, 8'h01, 1'b0, 1'b0, 7'd0,  1'b1}},
      '{PUT, CR,    1'b1, 8'd1,  1'b1, '{1'b1, CR,    1'b0, 1'b0, 7'd0,  1'b1}},
      '{PUT, LF,    1'b0, 8'd1,  1'b0, NO_RES},
      '{PUT, 8'hFE, 1'b1, 8'd1,  1'b0, NO_RES},
      '{EVT, 8'h7F, 1'b1, 8'd3,  1'b0, NO_RES},
      '{EVT, 8'hFF, 1'b1, 8'd1,  1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 7'd0,  1'b1}}
   };

   // shadow of the queue state
   logic [utq_pkg::BYTE_W-1:0] shadow_bytes [utq_pkg::QUEUE_DEPTH];
   int                         shadow_wr;
   int                         shadow_rd;
   int                         shadow_count;
   logic                       shadow_irq;

   tx_result_type tx_results_due [$];
   int            mismatches;
   int            send_idle_pct;
   int            recv_idle_pct;
   bit            hold_request;
   bit            hold_done = 1'b0;
   int            hold_left = 0;
   int            quiet_cycles = 0;

   function automatic void log_result(logic wr, logic [7:0] b, logic rej, logic is_last);
      tx_result_type r;
      r.dr_write      = wr;
      r.dr_byte       = b;
      r.irq_enable    = shadow_irq;
      r.rejected_full = rej;
      r.fill_level    = shadow_count[utq_pkg::FILL_W-1:0];
      r.last          = is_last;
      tx_results_due.push_back(r);
   endfunction

   function automatic bit queue_byte(logic [7:0] b, bit free, logic is_last);
      if (shadow_count == 0 && free) begin
         log_result(1'b1, b, 1'b0, is_last);
         return 1'b1;
      end
      if (shadow_count >= utq_pkg::QUEUE_DEPTH) begin
         log_result(1'b0, 8'h00, 1'b1, is_last);
         return 1'b0;
      end
      shadow_bytes[shadow_wr] = b;
      shadow_wr    = (shadow_wr + 1) % utq_pkg::QUEUE_DEPTH;
      shadow_count = shadow_count + 1;
      shadow_irq   = 1'b1;
      log_result(1'b0, 8'h00, 1'b0, is_last);
      return 1'b0;
   endfunction

   function automatic void predict_tx_item(logic op, logic [7:0] ch, logic te);
      bit direct;
      logic [7:0] b;
      if (op == utq_pkg::OP_PUT) begin
         if (ch == utq_pkg::LINE_FEED) begin
            direct = queue_byte(utq_pkg::CARRIAGE_RETURN, te, 1'b0);
            void'(queue_byte(utq_pkg::LINE_FEED, te && !direct, 1'b1));
         end else begin
            void'(queue_byte(ch, te, 1'b1));
         end
      end else if (te && shadow_count > 0) begin
         b = shadow_bytes[shadow_rd];
         shadow_rd    = (shadow_rd + 1) % utq_pkg::QUEUE_DEPTH;
         shadow_count = shadow_count - 1;
         log_result(1'b1, b, 1'b0, 1'b1);
      end else begin
         if (te) shadow_irq = 1'b0;
         log_result(1'b0, 8'h00, 1'b0, 1'b1);
      end
   endfunction

   task automatic send_item(logic op, logic [7:0] ch, logic te, logic typed,
                            tx_result_type res);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid             <= 1'b1;
      req_operation         <= op;
      req_tx_char           <= ch;
      req_transmitter_empty <= te;
      do @(posedge clock); while (req_stall);
      predict_tx_item(op, ch, te);
      if (typed) begin
         void'(tx_results_due.pop_back());
         tx_results_due.push_back(res);
      end
      @(negedge clock);
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver side stalls
   always @(negedge clock) begin
      if (hold_request && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      tx_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tx_results_due.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual dr_byte %0d", $time,
                     rsp_dr_byte);
            mismatches++;
         end else begin
            want = tx_results_due.pop_front();
            check_field("dr_write", want.dr_write, rsp_dr_write);
            check_field("dr_byte", want.dr_byte, rsp_dr_byte);
            check_field("irq_enable", want.irq_enable, rsp_irq_enable);
            check_field("rejected_full", want.rejected_full, rsp_rejected_full);
            check_field("fill_level", want.fill_level, rsp_fill_level);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STUCK_LIMIT) begin
            $display("uart_tx_queue_with_crlf test failed");
            $finish;
         end
      end
   end

   initial begin
      int   sent;
      int   n;
      int   kind;
      logic op;
      logic [7:0] ch;
      logic te;
      reset                 = 1'b1;
      req_valid             = 1'b0;
      req_operation         = utq_pkg::OP_PUT;
      req_tx_char           = 8'h00;
      req_transmitter_empty = 1'b0;
      shadow_wr             = 0;
      shadow_rd             = 0;
      shadow_count          = 0;
      shadow_irq            = 1'b0;
      mismatches            = 0;
      hold_request          = 1'b0;
      send_idle_pct         = 25;
      recv_idle_pct         = 80;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         repeat (directed_rows[i].reps)
            send_item(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].te,
                      directed_rows[i].typed, directed_rows[i].res);

      hold_request = 1'b1;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent >= 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (sent >= RANDOM_ITEMS / 3) begin
            send_idle_pct = 80;
            recv_idle_pct = 25;
         end
         kind = $urandom_range(9);
         n    = (kind < 7) ? $urandom_range(1, 70) : $urandom_range(1, 20);
         repeat (n) begin
            ch = ($urandom_range(5) == 0) ? utq_pkg::LINE_FEED : 8'($urandom_range(255));
            if (kind < 4) begin
               // filling burst
               op = utq_pkg::OP_PUT;
               te = ($urandom_range(9) == 0);
            end else if (kind < 7) begin
               // draining burst
               op = utq_pkg::OP_EVENT;
               te = ($urandom_range(7) != 0);
            end else begin
               op = 1'($urandom_range(1));
               te = 1'($urandom_range(1));
            end
            send_item(op, ch, te, 1'b0, NO_RES);
            sent++;
         end
      end
      req_valid <= 1'b0;

      while (tx_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0) begin
         $display("uart_tx_queue_with_crlf test passed");
      end else begin
         $display("uart_tx_queue_with_crlf test failed");
      end
      $finish;
   end

endmodule

[files.f]
sv/utq_pkg.sv
sv/utq_front.sv
sv/utq_opq.sv
sv/utq_back.sv
sv/uart_tx_queue_with_crlf.sv
dv/tb_uart_tx_queue_with_crlf.sv
